[sv/lifo_stack_with_search_core_defines.svh]
// ---------------------------------------------------------------------------
// LIFO stack with search: assertion macros
// Shared property wrappers for the stack core checks.
// ---------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SEARCH_CORE_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lss_pkg.sv]
// ---------------------------------------------------------------------------
// LIFO stack with search: package
// Sizes, request and status codes, and the types shared by the stack core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 7;
  localparam int REQ_W       = 2;
  localparam int STAT_W      = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int IN_TDATA_W  = 32;
  localparam int RES_W       = STAT_W + WORD_W + 1 + WORD_W + ENTRY_W + 1;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     empty;
    logic [ENTRY_W-1:0]       count;
    logic signed [WORD_W-1:0] top;
    logic                     found;
    logic signed [WORD_W-1:0] popped;
    logic [STAT_W-1:0]        status;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic             take;
    kind_t            kind;
    logic [CNT_W-1:0] count;
  } bk_stat_t;

endpackage

`default_nettype wire

[sv/lss_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

[sv/lss_queue.sv]
// ---------------------------------------------------------------------------
// LIFO stack with search: command queue
// Short FIFO of classified requests between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lss_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  lss_pkg::cmd_t wr_data,
  output logic          rd_valid,
  output lss_pkg::cmd_t rd_data,
  input  logic          rd_take
);

  lss_pkg::cmd_t                q_r [lss_pkg::QUEUE_DEPTH];
  logic [lss_pkg::QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [lss_pkg::QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [lss_pkg::QPTR_W:0]     fill_r, fill_nxt;
  logic                         push, pop;

  assign wr_ready = (fill_r != (lss_pkg::QPTR_W + 1)'(lss_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_data  = q_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_take && rd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == lss_pkg::QPTR_W'(lss_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wptr_r + lss_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == lss_pkg::QPTR_W'(lss_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rptr_r + lss_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + (lss_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (lss_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[sv/lss_front.sv]
// ---------------------------------------------------------------------------
// LIFO stack with search: front part
// Accept requests, decode the request kind and queue them for the back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lss_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lss_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [lss_pkg::REQ_W-1:0]        in_tuser,
  output logic                             cmd_valid,
  output lss_pkg::cmd_t                    cmd,
  input  logic                             cmd_take
);

  lss_pkg::cmd_t dec_cmd;

  always_comb begin
    dec_cmd.value = $signed(in_tdata[lss_pkg::WORD_W-1:0]);
    unique case (in_tuser)
      lss_pkg::REQ_PUSH:   dec_cmd.kind = lss_pkg::KIND_PUSH;
      lss_pkg::REQ_POP:    dec_cmd.kind = lss_pkg::KIND_POP;
      lss_pkg::REQ_SEARCH: dec_cmd.kind = lss_pkg::KIND_SEARCH;
      default:             dec_cmd.kind = lss_pkg::KIND_NOP;
    endcase
  end

  lss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (dec_cmd),
    .rd_valid (cmd_valid),
    .rd_data  (cmd),
    .rd_take  (cmd_take)
  );

endmodule

`default_nettype wire

[sv/lss_back.sv]
// ---------------------------------------------------------------------------
// LIFO stack with search: back part
// Execute queued requests against the stack memory and hold each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  lss_pkg::cmd_t     cmd,
  output logic              cmd_take,
  output logic              res_valid,
  output lss_pkg::res_t     res,
  input  logic              res_ready,
  output lss_pkg::bk_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_POPRD  = 3'b010,
    ST_SEARCH = 3'b100
  } state_t;

  state_t                                state_r, state_nxt;
  logic [lss_pkg::CNT_W-1:0]             count_r, count_nxt;
  logic signed [lss_pkg::WORD_W-1:0]     top_r, top_nxt;
  logic signed [lss_pkg::WORD_W-1:0]     key_r, key_nxt;
  logic signed [lss_pkg::WORD_W-1:0]     popped_r, popped_nxt;
  logic [lss_pkg::ADDR_W-1:0]            idx_r, idx_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  lss_pkg::res_t                         res_r, res_nxt;

  logic                                  out_free, load;
  logic [lss_pkg::STAT_W-1:0]            ld_status;
  logic signed [lss_pkg::WORD_W-1:0]     ld_popped;
  logic                                  ld_found;
  logic [lss_pkg::CNT_W-1:0]             pop_addr;

  logic                                  wr_en;
  logic [lss_pkg::ADDR_W-1:0]            wr_addr, rd_addr;
  logic [lss_pkg::WORD_W-1:0]            rd_data;

  assign out_free = !out_valid_r || res_ready;
  assign pop_addr = count_r - lss_pkg::CNT_TWO;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    key_nxt    = key_r;
    popped_nxt = popped_r;
    idx_nxt    = idx_r;
    cmd_take   = 1'b0;
    load       = 1'b0;
    ld_status  = lss_pkg::STAT_OK;
    ld_popped  = '0;
    ld_found   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count_r[lss_pkg::ADDR_W-1:0];
    rd_addr    = idx_r + lss_pkg::ADDR_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          unique case (cmd.kind)
            lss_pkg::KIND_PUSH: begin
              load = 1'b1;
              if (count_r == lss_pkg::CNT_MAX) begin
                ld_status = lss_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + lss_pkg::CNT_ONE;
                top_nxt   = cmd.value;
              end
            end
            lss_pkg::KIND_POP: begin
              if (count_r == lss_pkg::CNT_ZERO) begin
                load      = 1'b1;
                ld_status = lss_pkg::STAT_EMPTY;
                ld_popped = '1;
              end else if (count_r == lss_pkg::CNT_ONE) begin
                load      = 1'b1;
                ld_popped = top_r;
                count_nxt = lss_pkg::CNT_ZERO;
                top_nxt   = '0;
              end else begin
                popped_nxt = top_r;
                count_nxt  = count_r - lss_pkg::CNT_ONE;
                rd_addr    = pop_addr[lss_pkg::ADDR_W-1:0];
                state_nxt  = ST_POPRD;
              end
            end
            lss_pkg::KIND_SEARCH: begin
              if (count_r == lss_pkg::CNT_ZERO) begin
                load = 1'b1;
              end else begin
                key_nxt   = cmd.value;
                idx_nxt   = '0;
                rd_addr   = '0;
                state_nxt = ST_SEARCH;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_POPRD: begin
        top_nxt   = $signed(rd_data);
        ld_popped = popped_r;
        load      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SEARCH: begin
        if ($signed(rd_data) == key_r) begin
          ld_found  = 1'b1;
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else if (lss_pkg::CNT_W'(idx_r) == count_r - lss_pkg::CNT_ONE) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + lss_pkg::ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res_nxt = res_r;
    if (load) begin
      res_nxt.status = ld_status;
      res_nxt.popped = ld_popped;
      res_nxt.found  = ld_found;
      res_nxt.top    = top_nxt;
      res_nxt.count  = lss_pkg::ENTRY_W'(count_nxt);
      res_nxt.empty  = (count_nxt == lss_pkg::CNT_ZERO);
    end
    out_valid_nxt = load ? 1'b1 : (res_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    popped_r <= popped_nxt;
    idx_r    <= idx_nxt;
    res_r    <= res_nxt;
  end

  lss_ram #(
    .WIDTH (lss_pkg::WORD_W),
    .DEPTH (lss_pkg::STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_valid  = out_valid_r;
  assign res        = res_r;
  assign stat.busy  = (state_r != ST_IDLE);
  assign stat.take  = cmd_take;
  assign stat.kind  = cmd.kind;
  assign stat.count = count_r;

endmodule

`default_nettype wire

[sv/lifo_stack_with_search_core.sv]
// ---------------------------------------------------------------------------
// LIFO stack with search: top level
// Stack of signed 32-bit words with push, pop and search requests.
// ---------------------------------------------------------------------------
// Requests enter on in_*: in_tuser is the request kind, in_tdata the word.
// One result per request leaves on out_* with status, popped word, search
// hit, top word, entry count and empty flag, all after the request.
// A two-entry command queue separates intake from execution, so requests
// are accepted while a result waits on a stalled receiver.
// Push, empty pop, pop of the last entry, search of an empty stack and
// unused kinds load their result straight from the idle state; pop with
// more than one entry left goes through ST_POPRD (the new top is read back
// from the stack RAM); search steps through ST_SEARCH from the bottom entry
// up to the first match or the top entry, one RAM read a cycle.
// Pushes are taken at one request per cycle while out_tready stays high.
// A stalled out_tready holds the result register; the back part stops and
// the queue fills, then in_tready drops.
// Reset clears the entry count, queue and result valid; stack RAM contents
// are left as they are and need no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_stack_with_search_core_defines.svh"

module lifo_stack_with_search_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] value
  input  logic [lss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [lss_pkg::REQ_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [33:2] popped_value, [34] found, [66:35] top_value,
  // [73:67] entry_count, [74] is_empty, [79:75] zero
  output logic [lss_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic              cmd_valid, cmd_take;
  lss_pkg::cmd_t     cmd;
  lss_pkg::res_t     res;
  lss_pkg::bk_stat_t bk_stat;

  lss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  lss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready),
    .stat      (bk_stat)
  );

  assign out_tdata = {{lss_pkg::OUT_PAD_W{1'b0}}, res};

  `LSS_ASSERT_NOW(a_count_bound, 1'b1, bk_stat.count <= lss_pkg::CNT_MAX, "count beyond depth")
  `LSS_ASSERT_NOW(a_busy_no_result, bk_stat.busy, !out_tvalid, "result shown while busy")
  `LSS_ASSERT_NEXT(a_push_count, bk_stat.take && bk_stat.kind == lss_pkg::KIND_PUSH && bk_stat.count != lss_pkg::CNT_MAX, bk_stat.count == $past(bk_stat.count) + lss_pkg::CNT_ONE, "push did not advance count")
  `LSS_ASSERT_NOW(a_empty_top, out_tvalid && res.empty, res.top == '0 && res.count == '0, "empty result with top or count")

endmodule

`default_nettype wire

[test/tb_lifo_stack_with_search_core.sv]
// ---------------------------------------------------------------------------
// LIFO stack with search: testbench
// Drives push, pop, search and unused-kind requests into the stack core,
// mirrors the stack contents and count, and checks every result field.
// Directed corner requests come first, then random runs that push the stack
// toward overflow, drain it past empty and search it on the way, with
// random idle cycles on both request and result sides except in one segment.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lifo_stack_with_search_core;
  import lss_pkg::*;

  class stack_mirror;
    logic signed [WORD_W-1:0] words [STACK_DEPTH];
    int depth;
    int mismatches;
    res_t pending_results [$];

    function new();
      depth = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void take_request(kind_t kind, logic signed [WORD_W-1:0] value);
      res_t r;
      r = '0;
      case (kind)
        KIND_PUSH: begin
          if (depth >= STACK_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            words[depth] = value;
            depth++;
          end
        end
        KIND_POP: begin
          if (depth == 0) begin
            r.status = STAT_EMPTY;
            r.popped = '1;
          end else begin
            r.popped = words[depth-1];
            depth--;
          end
        end
        KIND_SEARCH: begin
          for (int i = 0; i < depth; i++) begin
            if (words[i] == value) r.found = 1'b1;
          end
        end
        default: ;
      endcase
      r.top   = (depth == 0) ? '0 : words[depth-1];
      r.count = ENTRY_W'(depth);
      r.empty = (depth == 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      res_t got;
      res_t want;
      logic [OUT_PAD_W-1:0] pad;
      got = data[RES_W-1:0];
      pad = data[OUT_TDATA_W-1:RES_W];
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h", data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.popped !== want.popped) begin
        $error("popped_value: expected %h, got %h", want.popped, got.popped);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.top !== want.top) begin
        $error("top_value: expected %h, got %h", want.top, got.top);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
      if (got.empty !== want.empty) begin
        $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
        mismatches++;
      end
      if (pad !== '0) begin
        $error("padding: expected 0, got %h", pad);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  stack_mirror mirror;
  bit steady = 1'b0;
  int sent = 0;

  lifo_stack_with_search_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_result(out_tdata);
  end

  task automatic issue(kind_t kind, logic [WORD_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    mirror.take_request(kind, value);
    sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (mirror.outstanding() != 0);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return WORD_W'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return -WORD_W'($urandom_range(1, 8));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_probe();
    if (mirror.depth > 0 && $urandom_range(0, 99) < 55)
      return mirror.words[$urandom_range(0, mirror.depth - 1)];
    return pick_word();
  endfunction

  task automatic random_run(int mode, int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      case (mode)
        0: r = (r < 75) ? 0 : (r < 83) ? 1 : (r < 97) ? 2 : 3;
        1: r = (r < 15) ? 0 : (r < 75) ? 1 : (r < 97) ? 2 : 3;
        default: r = (r < 40) ? 0 : (r < 75) ? 1 : (r < 96) ? 2 : 3;
      endcase
      case (r)
        0: issue(KIND_PUSH, pick_word());
        1: issue(KIND_POP, pick_word());
        2: issue(KIND_SEARCH, pick_probe());
        default: issue(KIND_NOP, pick_word());
      endcase
    end
  endtask

  initial begin
    int seg;
    mirror = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(KIND_POP, 32'h0000_0000);
    issue(KIND_SEARCH, 32'h0000_0000);
    issue(KIND_NOP, 32'hFFFF_FFFF);
    issue(KIND_PUSH, 32'h8000_0000);
    issue(KIND_PUSH, 32'h7FFF_FFFF);
    issue(KIND_PUSH, 32'h0000_0000);
    issue(KIND_PUSH, 32'hFFFF_FFFF);
    issue(KIND_SEARCH, 32'h8000_0000);
    issue(KIND_SEARCH, 32'h7FFF_FFFF);
    issue(KIND_SEARCH, 32'hFFFF_FFFF);
    issue(KIND_SEARCH, 32'h1234_5678);
    issue(KIND_NOP, 32'h5555_AAAA);
    issue(KIND_PUSH, 32'h7FFF_FFFF);
    issue(KIND_SEARCH, 32'h7FFF_FFFF);
    repeat (5) issue(KIND_POP, 32'hAAAA_5555);
    issue(KIND_POP, 32'h0000_0000);
    issue(KIND_PUSH, 32'h0000_0001);
    issue(KIND_POP, 32'h0000_0000);
    issue(KIND_SEARCH, 32'h0000_0001);
    wait_drained();

    random_run(0, 100);
    seg = 0;
    while (sent < 810) begin
      if ($urandom_range(0, 3) == 0) wait_drained();
      steady = (seg == 3);
      random_run($urandom_range(0, 2), $urandom_range(30, 120));
      seg++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (80) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/lss_pkg.sv
sv/lss_ram.sv
sv/lss_queue.sv
sv/lss_front.sv
sv/lss_back.sv
sv/lifo_stack_with_search_core.sv
test/tb_lifo_stack_with_search_core.sv
